// ===== rtl/kmam_pkg.sv =====
// Shared types and constants for the knob moving-average mapper.
package kmam_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned FULL_SCALE_DEF  = 4095;

  localparam int unsigned WIN_W  = 5;
  localparam int unsigned RNG_W  = 16;
  localparam int unsigned THR_W  = 12;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [WIN_W-1:0]        WIN_RESET      = 5'd10;
  localparam logic signed [RNG_W-1:0] RANGE_MIN_RESET = 16'sd0;
  localparam logic signed [RNG_W-1:0] RANGE_MAX_RESET = 16'sd100;
  localparam logic [THR_W-1:0]        THR_RESET      = 12'd10;
  localparam logic [PCT_W-1:0]        PCT_FULL       = 7'd100;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_WINDOW    = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_AVG,
    ST_MAP,
    ST_MAPDIV,
    ST_PCT,
    ST_OUT
  } kmam_state_e;

endpackage

// ===== rtl/kmam_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module kmam_div #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_nx;
  logic             ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign rem_d  = rem_nx[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      busy_q <= (cnt_q != CNT_W'(1));
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/knob_moving_average_mapper.sv =====
// Knob moving-average mapper: ring-buffer boxcar filter, linear range map, change flag.
// Steps with smoothing on: ring update, serial mean divide, range product, range scale,
//   percent scale and range finish, output; with smoothing off the first two are skipped.
// Flow: one transaction at a time, the next accepted in the cycle after the result is
//   registered; a result cannot be registered while the previous one still waits in
//   the output register for out_ready_i.
// Reset: asynchronous, active low; clears control, ring position, wrap flag, running total,
//   previous result and loads register defaults. Ring memory contents are not cleared.
module knob_moving_average_mapper
  import kmam_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FULL_SCALE  = FULL_SCALE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // APB configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  // sample input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_BITS-1:0]  filtered_value_o,
  output logic signed [RNG_W-1:0] mapped_value_o,
  output logic [PCT_W-1:0]        percent_value_o,
  output logic                    changed_o
);

  // Widths derived from parameters
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned TOT_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned DIV_W = SAMPLE_BITS + RNG_W;
  localparam int unsigned SUM_W = DIV_W + 2;
  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  // Reciprocal for the division by full scale: floor(n / FULL_SCALE) equals
  // (n * RcpMul) >> RCP_K for every n below 2**DIV_W.
  localparam int unsigned RCP_L  = $clog2(FULL_SCALE);
  localparam int unsigned RCP_K  = DIV_W + RCP_L;
  localparam int unsigned RCP_W  = DIV_W + 1;
  localparam int unsigned PROD_W = DIV_W + RCP_W;
  localparam logic [63:0] RcpFull =
    ((64'd1 << RCP_K) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam logic [RCP_W-1:0] RcpMul = RcpFull[RCP_W-1:0];

  localparam logic signed [SUM_W-1:0] MapHi = SUM_W'(2 ** (RNG_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] MapLo = -SUM_W'(2 ** (RNG_W - 1));

  // Configuration registers
  logic                    en_q;
  logic [WIN_W-1:0]        win_q;
  logic signed [RNG_W-1:0] rmin_q;
  logic signed [RNG_W-1:0] rmax_q;
  logic [THR_W-1:0]        thr_q;

  // Filter state
  logic [PTR_W-1:0]        pos_q;
  logic                    wrapped_q;
  logic [TOT_W-1:0]        total_q;
  logic [SAMPLE_BITS-1:0]  prev_q;

  // Per-transaction working registers
  kmam_state_e             state_q, state_d;
  logic [SAMPLE_BITS-1:0]  samp_q;
  logic [SAMPLE_BITS-1:0]  filt_q;
  logic                    neg_q;
  logic                    chg_q;
  logic [DIV_W-1:0]        prod_q;
  logic [DIV_W-1:0]        quot_q;
  logic signed [RNG_W-1:0] map_q;
  logic [PCT_W-1:0]        pct_q;

  // Output register
  logic                    out_valid_q;
  logic [SAMPLE_BITS-1:0]  out_filt_q;
  logic signed [RNG_W-1:0] out_map_q;
  logic [PCT_W-1:0]        out_pct_q;
  logic                    out_chg_q;

  // Ring memory with registered read
  logic [SAMPLE_BITS-1:0]  ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]  ring_rd_q;

  // Control from the FSM
  logic                    in_ready;
  logic                    div_start;
  logic [TOT_W-1:0]        div_num;
  logic [CNT_W-1:0]        div_den;
  logic                    ring_we;
  logic                    out_load;

  // Divider status
  logic                    div_busy;
  logic                    div_done;
  logic [TOT_W-1:0]        div_quot;

  // Datapath signals
  logic                    cfg_wr;
  logic [2:0]              cfg_idx;
  logic [CNT_W-1:0]        w_eff;
  logic [CNT_W-1:0]        pos_p1;
  logic                    wrap_now;
  logic [PTR_W-1:0]        pos_nx;
  logic [CNT_W-1:0]        count;
  logic [TOT_W-1:0]        total_nx;
  logic signed [RNG_W:0]   span;
  logic [RNG_W-1:0]        span_mag;
  logic [DIV_W-1:0]        map_prod;
  logic [DIV_W-1:0]        pct_prod;
  logic [PROD_W-1:0]       rcp_prod;
  logic [DIV_W-1:0]        rcp_quot;
  logic [SAMPLE_BITS-1:0]  diff;
  logic signed [SUM_W-1:0] map_q_ext;
  logic signed [SUM_W-1:0] map_sum;
  logic signed [RNG_W-1:0] map_sat;
  logic [PCT_W-1:0]        pct_sat;

  // ---------------------------------------------------------------------------
  // Configuration port: zero-wait APB, write on the access phase.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:    prdata = APB_DW'(en_q);
      REG_WINDOW:    prdata = APB_DW'(win_q);
      REG_RANGE_MIN: prdata = APB_DW'(rmin_q);
      REG_RANGE_MAX: prdata = APB_DW'(rmax_q);
      REG_THRESHOLD: prdata = APB_DW'(thr_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective window: zero acts as one, oversize clamps to the ring depth.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (win_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(win_q) > int'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(win_q);
    end
  end

  // Ring pointer advance and running-sum update. The read of the oldest entry
  // was launched at accept time and lands in ring_rd_q during ST_RING.
  assign pos_p1   = CNT_W'(pos_q) + CNT_W'(1);
  assign wrap_now = (pos_p1 >= w_eff);
  assign pos_nx   = wrap_now ? '0 : pos_p1[PTR_W-1:0];
  assign count    = (wrap_now || wrapped_q) ? w_eff : pos_p1;
  assign total_nx = total_q - (wrapped_q ? TOT_W'(ring_rd_q) : '0) + TOT_W'(samp_q);

  // Linear map operands: magnitude division, sign restored afterwards.
  assign span     = {rmax_q[RNG_W-1], rmax_q} - {rmin_q[RNG_W-1], rmin_q};
  assign span_mag = span[RNG_W] ? RNG_W'(-span) : span[RNG_W-1:0];
  assign map_prod = DIV_W'(filt_q) * DIV_W'(span_mag);
  assign pct_prod = DIV_W'(filt_q) * DIV_W'(PCT_FULL);

  // Division by full scale through the reciprocal, one product per cycle.
  assign rcp_prod = PROD_W'(prod_q) * PROD_W'(RcpMul);
  assign rcp_quot = DIV_W'(rcp_prod >> RCP_K);

  assign diff = (filt_q > prev_q) ? (filt_q - prev_q) : (prev_q - filt_q);

  // Restore sign, add range_min, saturate to the 16-bit result.
  assign map_q_ext = neg_q ? -$signed({2'b00, quot_q}) : $signed({2'b00, quot_q});
  assign map_sum   = map_q_ext + SUM_W'(rmin_q);

  always_comb begin
    if (map_sum > MapHi) begin
      map_sat = RNG_W'(MapHi);
    end else if (map_sum < MapLo) begin
      map_sat = RNG_W'(MapLo);
    end else begin
      map_sat = map_sum[RNG_W-1:0];
    end
  end

  assign pct_sat = (rcp_quot > DIV_W'(PCT_FULL)) ? PCT_FULL : rcp_quot[PCT_W-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ring_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = en_q ? ST_RING : ST_MAP;
        end
      end
      ST_RING: begin
        // retire the oldest entry, store the new one, start the mean
        ring_we   = 1'b1;
        div_start = 1'b1;
        div_num   = total_nx;
        div_den   = count;
        state_d   = ST_AVG;
      end
      ST_AVG: begin
        if (div_done) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        // form the range product
        state_d = ST_MAPDIV;
      end
      ST_MAPDIV: begin
        // scale the range product, form the percent product
        state_d = ST_PCT;
      end
      ST_PCT: begin
        // scale the percent product, finish the range map
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = in_ready;

  // ---------------------------------------------------------------------------
  // Configuration and filter state. A change of enable or window restarts the
  // ring count; writing the same value leaves it alone.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      win_q     <= WIN_RESET;
      rmin_q    <= RANGE_MIN_RESET;
      rmax_q    <= RANGE_MAX_RESET;
      thr_q     <= THR_RESET;
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      total_q   <= '0;
      prev_q    <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_ENABLE: begin
            if (pwdata[0] != en_q) begin
              en_q      <= pwdata[0];
              pos_q     <= '0;
              wrapped_q <= 1'b0;
              total_q   <= '0;
            end
          end
          REG_WINDOW: begin
            if (pwdata[WIN_W-1:0] != win_q) begin
              win_q     <= pwdata[WIN_W-1:0];
              pos_q     <= '0;
              wrapped_q <= 1'b0;
              total_q   <= '0;
            end
          end
          REG_RANGE_MIN: rmin_q <= pwdata[RNG_W-1:0];
          REG_RANGE_MAX: rmax_q <= pwdata[RNG_W-1:0];
          REG_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_RING) begin
        pos_q     <= pos_nx;
        wrapped_q <= wrapped_q || wrap_now;
        total_q   <= total_nx;
      end
      if (state_q == ST_MAP) begin
        prev_q <= filt_q;
      end
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= samp_q;
    end
    if (in_ready && in_valid_i) begin
      ring_rd_q <= ring_mem[pos_q];
    end
  end

  // Working registers of the transaction in flight
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      samp_q <= sample_i;
      filt_q <= sample_i;
    end
    if (state_q == ST_AVG && div_done) begin
      filt_q <= div_quot[SAMPLE_BITS-1:0];
    end
    if (state_q == ST_MAP) begin
      neg_q  <= span[RNG_W];
      chg_q  <= (CMP_W'(diff) > CMP_W'(thr_q));
      prod_q <= map_prod;
    end
    if (state_q == ST_MAPDIV) begin
      quot_q <= rcp_quot;
      prod_q <= pct_prod;
    end
    if (state_q == ST_PCT) begin
      map_q <= map_sat;
      pct_q <= pct_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: a result waits here while the next sample is taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_filt_q <= filt_q;
      out_map_q  <= map_q;
      out_pct_q  <= pct_q;
      out_chg_q  <= chg_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_filt_q;
  assign mapped_value_o   = out_map_q;
  assign percent_value_o  = out_pct_q;
  assign changed_o        = out_chg_q;

  // Serial divider for the mean over the ring
  kmam_div #(
    .NUM_W(TOT_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

`ifndef NO_ASSERTIONS
  // The divider is never restarted while a division is still running.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // Ring position stays inside the active window whenever a sample may arrive.
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && en_q) |-> (CNT_W'(pos_q) < w_eff))
    else $error("ring position outside window");

  // A division result only shows up while the sequencer waits for one.
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_AVG))
    else $error("unexpected divider completion");

  // A delivered percentage never exceeds full scale.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (percent_value_o <= PCT_FULL))
    else $error("percent value above 100");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the knob moving-average mapper.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmam_pkg::*;

  // Run shape. The quiet-cycle limit leaves a wide margin over the slowest correct
  // transaction, including a long receiver stall on top of it.
  localparam int          RESET_CYCLES       = 5;
  localparam int          ITEMS_PER_SEGMENT  = 50;
  localparam int          SEGMENTS_PER_PHASE = 3;
  localparam int          IDLE_PHASES        = 4;
  localparam int          QUIET_LIMIT        = 4000;
  localparam int          DRAIN_CYCLES       = 100;
  localparam int          MAX_REPORTS        = 10;
  localparam int          REG_SLOTS          = 8;
  localparam int          SAMPLE_TOP         = 4095;
  localparam longint      FULL_SCALE_L       = longint'(FULL_SCALE_DEF);
  localparam longint      MAP_TOP            = 32767;
  localparam longint      MAP_BOTTOM         = -32768;

  // Idling per phase: none, sender only, receiver only, both.
  localparam int unsigned SEND_IDLE_PCT  [IDLE_PHASES] = '{0, 55, 0, 31};
  localparam int unsigned RECV_STALL_PCT [IDLE_PHASES] = '{0, 0, 55, 31};

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] filt;
    logic signed [RNG_W-1:0]    mapped;
    logic [PCT_W-1:0]           pct;
    logic                       changed;
  } knob_result_t;

  // Block ports; every input starts at a known value.
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [APB_AW-1:0]          paddr       = '0;
  logic [APB_DW-1:0]          pwdata      = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [SAMPLE_BITS_DEF-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [SAMPLE_BITS_DEF-1:0] filtered_value_o;
  logic signed [RNG_W-1:0]    mapped_value_o;
  logic [PCT_W-1:0]           percent_value_o;
  logic                       changed_o;

  // Samples waiting to be driven, and the results the filter owes us in order.
  logic [SAMPLE_BITS_DEF-1:0] sample_feed_q[$];
  knob_result_t               due_results_q[$];

  // Handshake bookkeeping shared between the edge processes.
  logic                       in_taken       = 1'b0;
  int unsigned                send_idle_pct  = 0;
  int unsigned                recv_stall_pct = 0;
  int                         quiet_cycles   = 0;
  int                         fail_count     = 0;
  knob_result_t               want_r;

  // Our own copy of the register file, at reset values.
  logic                       smooth_en  = 1'b0;
  logic [WIN_W-1:0]           win_len    = WIN_RESET;
  shortint                    range_lo   = RANGE_MIN_RESET;
  shortint                    range_hi   = RANGE_MAX_RESET;
  logic [THR_W-1:0]           chg_thr    = THR_RESET;

  // Our own copy of the filter state.
  logic [SAMPLE_BITS_DEF-1:0] ring_mem [MAX_WINDOW_DEF] = '{default: '0};
  logic [31:0]                ring_pos   = '0;
  logic [31:0]                ring_sum   = '0;
  logic                       ring_full  = 1'b0;
  logic [SAMPLE_BITS_DEF-1:0] last_filt  = '0;

  knob_moving_average_mapper i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_value_o (filtered_value_o),
    .mapped_value_o   (mapped_value_o),
    .percent_value_o  (percent_value_o),
    .changed_o        (changed_o)
  );

  always #5 clk_i = ~clk_i;

  // Drop the ring count back to empty; the ring contents stay as they are.
  function automatic void ring_reset();
    ring_pos  = '0;
    ring_full = 1'b0;
    ring_sum  = '0;
  endfunction

  // Mirror a register write. Enable and window only clear the count when the
  // value actually changes; unknown indexes fall through untouched.
  function automatic void shadow_write(input logic [2:0] idx, input logic [31:0] word);
    case (idx)
      REG_ENABLE: begin
        if (word[0] != smooth_en) begin
          smooth_en = word[0];
          ring_reset();
        end
      end
      REG_WINDOW: begin
        if (word[WIN_W-1:0] != win_len) begin
          win_len = word[WIN_W-1:0];
          ring_reset();
        end
      end
      REG_RANGE_MIN: range_lo = shortint'(word[RNG_W-1:0]);
      REG_RANGE_MAX: range_hi = shortint'(word[RNG_W-1:0]);
      REG_THRESHOLD: chg_thr = word[THR_W-1:0];
      default: ;
    endcase
  endfunction

  // Boxcar-average one sample (when smoothing is on), map it to the range and to
  // percent, and flag a jump against the previous result.
  function automatic knob_result_t filter_and_map(input logic [SAMPLE_BITS_DEF-1:0] s);
    knob_result_t               r;
    logic [31:0]                w;
    logic [31:0]                pos;
    logic [31:0]                count;
    logic [31:0]                filt;
    logic [SAMPLE_BITS_DEF-1:0] f12;
    logic [SAMPLE_BITS_DEF-1:0] diff;
    longint                     span_m;
    longint                     pct_m;
    filt = 32'(s);
    if (smooth_en) begin
      // Window zero behaves as one, anything past the ring depth as the full ring.
      if (win_len == 0) w = 1;
      else if (win_len > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
      else w = 32'(win_len);
      pos = ring_pos % w;
      if (ring_full) ring_sum = ring_sum - 32'(ring_mem[pos]);
      ring_mem[pos] = s;
      ring_sum      = ring_sum + 32'(s);
      pos           = pos + 1;
      if (pos >= w) begin
        pos       = 0;
        ring_full = 1'b1;
      end
      ring_pos = pos;
      count    = ring_full ? w : pos;
      filt     = (count > 0) ? ring_sum / count : 32'(s);
    end
    f12       = filt[SAMPLE_BITS_DEF-1:0];
    diff      = (f12 > last_filt) ? f12 - last_filt : last_filt - f12;
    last_filt = f12;

    // Division truncates toward zero, as in the Arduino-style map.
    span_m = longint'(f12) * (longint'(range_hi) - longint'(range_lo)) / FULL_SCALE_L
             + longint'(range_lo);
    if (span_m > MAP_TOP) span_m = MAP_TOP;
    if (span_m < MAP_BOTTOM) span_m = MAP_BOTTOM;
    pct_m = longint'(f12) * longint'(PCT_FULL) / FULL_SCALE_L;
    if (pct_m > longint'(PCT_FULL)) pct_m = longint'(PCT_FULL);
    if (pct_m < 0) pct_m = 0;

    r.filt    = f12;
    r.mapped  = span_m[RNG_W-1:0];
    r.pct     = pct_m[PCT_W-1:0];
    r.changed = (diff > chg_thr);
    return r;
  endfunction

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", what);
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] word);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_write(idx, word);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until the feed is empty and nothing is on the input (both stable at the
  // rising edge), then until every owed result has come back.
  task automatic wait_idle();
    do @(posedge clk_i); while (sample_feed_q.size() != 0 || in_valid_i);
    while (due_results_q.size() != 0) @(negedge clk_i);
  endtask

  // Sample driver and receiver backpressure, both on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    // Hold valid and payload until the transaction is taken; then advance or idle.
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (sample_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i   <= sample_feed_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor on the rising edge: predict on each accepted sample, check each
  // accepted result against the oldest prediction, and watch for a hang.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) due_results_q.push_back(filter_and_map(sample_i));
      if (out_valid_o && out_ready_i) begin
        if (due_results_q.size() == 0) begin
          log_failure($sformatf("unexpected result: filt %0d mapped %0d pct %0d chg %0b",
                                filtered_value_o, mapped_value_o, percent_value_o,
                                changed_o));
        end else begin
          want_r = due_results_q.pop_front();
          if (want_r.filt !== filtered_value_o || want_r.mapped !== mapped_value_o ||
              want_r.pct !== percent_value_o || want_r.changed !== changed_o) begin
            log_failure($sformatf({"result mismatch: expected filt %0d mapped %0d pct %0d ",
                                   "chg %0b, got filt %0d mapped %0d pct %0d chg %0b"},
                                  want_r.filt, want_r.mapped, want_r.pct, want_r.changed,
                                  filtered_value_o, mapped_value_o, percent_value_o,
                                  changed_o));
          end
        end
      end
      // Any transaction on either channel resets the quiet-cycle count.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[knob_moving_average_mapper] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus: a directed pass over the corners, then random knob traffic in
  // segments, each under a fresh register setting, across the idling phases.
  initial begin
    int          knob;
    int          delta;
    logic [31:0] junk;
    logic        en;
    logic [4:0]  win;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [11:0] thr;
    int          seg;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Raw mode at reset settings: full-scale swings, the threshold edge (a step
    // equal to the threshold stays quiet, one more raises the flag), bit patterns.
    @(posedge clk_i);
    sample_feed_q = '{12'd0, 12'd4095, 12'd0, 12'd10, 12'd21, 12'hAAA, 12'h555};
    wait_idle();

    // Widest range, zero threshold, smoothing on with window zero (acts as one).
    reg_write(REG_RANGE_MIN, 32'h0000_8000);
    reg_write(REG_RANGE_MAX, 32'h0000_7FFF);
    reg_write(REG_THRESHOLD, 32'h0000_0000);
    reg_write(REG_ENABLE, 32'h0000_0001);
    reg_write(REG_WINDOW, 32'h0000_0000);
    @(posedge clk_i);
    sample_feed_q = '{12'd4095, 12'd0, 12'd4095};
    wait_idle();

    // Reversed range, top threshold, two-entry ring that wraps.
    reg_write(REG_WINDOW, 32'h0000_0002);
    reg_write(REG_RANGE_MIN, 32'h0000_7FFF);
    reg_write(REG_RANGE_MAX, 32'h0000_8000);
    reg_write(REG_THRESHOLD, 32'h0000_0FFF);
    @(posedge clk_i);
    sample_feed_q = '{12'd4095, 12'd4095, 12'd0, 12'd0};
    wait_idle();

    // Rewrite the same window (keeps the ring count) and poke the unused slots.
    reg_write(REG_WINDOW, 32'h0000_0002);
    for (int r = REG_THRESHOLD + 1; r < REG_SLOTS; r++) reg_write(3'(r), $urandom());
    @(posedge clk_i);
    sample_feed_q = '{12'd4095};
    wait_idle();

    for (int phase = 0; phase < IDLE_PHASES; phase++) begin
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      for (int k = 0; k < SEGMENTS_PER_PHASE; k++) begin
        seg  = phase * SEGMENTS_PER_PHASE + k;
        junk = $urandom();
        en   = ($urandom_range(0, 3) != 0);
        win  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, MAX_WINDOW_DEF));
        lo   = 16'($urandom());
        hi   = 16'($urandom());
        thr  = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 64)) : 12'($urandom());
        // Pin the register extremes on the first segments.
        case (seg)
          0: begin
            en = 1'b1; win = 5'd16; lo = 16'h8000; hi = 16'h7FFF;
          end
          1: begin
            en = 1'b1; win = 5'd31; lo = 16'h7FFF; hi = 16'h8000; thr = 12'hFFF;
          end
          2: begin
            en = 1'b1; win = 5'd1; thr = '0;
          end
          3: en = 1'b0;
          default: ;
        endcase
        // Upper word bits carry junk the block must ignore.
        reg_write(REG_THRESHOLD, {junk[31:12], thr});
        reg_write(REG_RANGE_MIN, {junk[31:16], lo});
        reg_write(REG_RANGE_MAX, {junk[31:16], hi});
        reg_write(REG_WINDOW, {junk[31:5], win});
        reg_write(REG_ENABLE, {junk[31:1], en});
        if ($urandom_range(0, 3) == 0) begin
          reg_write(3'($urandom_range(REG_THRESHOLD + 1, REG_SLOTS - 1)), $urandom());
        end

        // Knob traffic: slow turns around the threshold as the largest share, some jumps,
        // end stops and a resting knob.
        @(posedge clk_i);
        knob = $urandom_range(0, SAMPLE_TOP);
        repeat (ITEMS_PER_SEGMENT) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              delta = int'($urandom_range(0, 2 * thr + 4)) - int'(thr) - 2;
              knob  = knob + delta;
              if (knob < 0) knob = 0;
              if (knob > SAMPLE_TOP) knob = SAMPLE_TOP;
            end
            4, 5, 6: knob = $urandom_range(0, SAMPLE_TOP);
            7: knob = ($urandom_range(0, 1) != 0) ? SAMPLE_TOP : 0;
            default: ;
          endcase
          sample_feed_q.push_back(12'(knob));
        end
        wait_idle();
      end
    end

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && due_results_q.size() == 0) begin
      $display("[knob_moving_average_mapper] OK");
    end else begin
      $display("[knob_moving_average_mapper] ERROR");
    end
    $finish;
  end

endmodule
